### hdl/cpdr_pkg.sv
// Shared constants and types for the periodic compact-difference RHS block.
// No dependencies; imported by every module of the block but the queue.
`default_nettype none

package cpdr_pkg;

  // default sizing, handed down from the top level
  localparam int DEF_MAX_LINE    = 4096;
  localparam int DEF_SAMPLE_BITS = 32;
  localparam int DEF_FRAC_BITS   = 24;

  // fixed register widths
  localparam int COEF_W         = 32;
  localparam int CFG_DATA_W     = 32;
  localparam int LINE_LEN_W     = 13;
  localparam int LINE_LEN_RESET = 64;
  localparam int MIN_LINE       = 7;
  localparam int REG_IDX_W      = 2;

  // stencil geometry
  localparam int HEAD_DEPTH    = 6;  // samples kept from the start of a line
  localparam int STENCIL_REACH = 3;  // middle results trail the input by this
  localparam int WIN_TAPS      = 7;  // six window taps plus the incoming sample
  localparam int WRAP_BASE_W   = 3;

  // job layout: window taps, then the six wrap-fetch values, then position and last flag
  localparam int SLOT_FOLD = WIN_TAPS;
  localparam int JOB_SLOTS = WIN_TAPS + HEAD_DEPTH;

  // queue depths, powers of two
  localparam int ITEM_Q_DEPTH = 4;
  localparam int OUT_Q_DEPTH  = 8;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_COEF_ONE,
    REG_COEF_TWO,
    REG_COEF_THREE,
    REG_LINE_LENGTH
  } reg_index_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] one;
    logic signed [COEF_W-1:0] two;
    logic signed [COEF_W-1:0] three;
  } coef_t;

endpackage

`default_nettype wire

### hdl/cpdr_queue.sv
// Small register-based FIFO, used for the job queue and the result queue.
// No package dependency; DEPTH must be a power of two, at least two.
`default_nettype none

module cpdr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

### hdl/cpdr_front.sv
// Front end: takes samples, keeps the line head and the sliding window,
// and turns every sample past the head into one job. Depends on cpdr_pkg.
`default_nettype none

module cpdr_front #(
  parameter int MAX_LINE    = cpdr_pkg::DEF_MAX_LINE,
  parameter int SAMPLE_BITS = cpdr_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  input  logic [SAMPLE_BITS-1:0]                 sample,
  output logic                                   full,
  input  logic [$clog2(MAX_LINE)-1:0]            len_last,
  input  logic [cpdr_pkg::WRAP_BASE_W-1:0]       wrap_base,
  input  logic                                   q_full,
  output logic                                   job_push,
  output logic [cpdr_pkg::JOB_SLOTS*SAMPLE_BITS+$clog2(MAX_LINE):0] job_data
);

  import cpdr_pkg::*;

  localparam int CNT_W   = $clog2(MAX_LINE);
  localparam int JOB_W   = JOB_SLOTS * SAMPLE_BITS + CNT_W + 1;
  localparam int HEAD_IW = $clog2(HEAD_DEPTH);

  logic [CNT_W-1:0]       cnt;
  logic [SAMPLE_BITS-1:0] head   [HEAD_DEPTH];
  logic [SAMPLE_BITS-1:0] window [HEAD_DEPTH];
  logic [SAMPLE_BITS-1:0] win    [WIN_TAPS];
  logic [SAMPLE_BITS-1:0] fold   [HEAD_DEPTH];
  logic                   in_head;
  logic                   last;
  logic                   accept;

  assign in_head  = (cnt < CNT_W'(HEAD_DEPTH));
  assign last     = (cnt >= len_last);
  assign full     = q_full && !in_head;
  assign accept   = push && !full;
  assign job_push = accept && !in_head;

  // fold[j] is sample j of the line as seen at the line end: short lines
  // overlap the head with the window, and the window wins there
  always_comb begin
    logic [WRAP_BASE_W-1:0] idx;
    idx = '0;
    for (int k = 0; k < HEAD_DEPTH; k++) begin
      win[k] = window[k];
    end
    win[HEAD_DEPTH] = sample;
    for (int j = 0; j < HEAD_DEPTH; j++) begin
      idx = WRAP_BASE_W'(j) - wrap_base + WRAP_BASE_W'(1);
      if (WRAP_BASE_W'(j) >= wrap_base) fold[j] = win[idx];
      else fold[j] = head[j];
    end
    for (int k = 0; k < WIN_TAPS; k++) begin
      job_data[k*SAMPLE_BITS +: SAMPLE_BITS] = win[k];
    end
    for (int j = 0; j < HEAD_DEPTH; j++) begin
      job_data[(SLOT_FOLD+j)*SAMPLE_BITS +: SAMPLE_BITS] = fold[j];
    end
    job_data[JOB_SLOTS*SAMPLE_BITS +: CNT_W] = cnt - CNT_W'(STENCIL_REACH);
    job_data[JOB_W-1] = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept) begin
      cnt <= last ? '0 : cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (in_head) head[cnt[HEAD_IW-1:0]] <= sample;
      for (int k = 0; k < HEAD_DEPTH - 1; k++) begin
        window[k] <= window[k+1];
      end
      window[HEAD_DEPTH-1] <= sample;
    end
  end

endmodule

`default_nettype wire

### hdl/cpdr_back.sv
// Back end: expands jobs into results (one, or seven at a line end) and runs
// the multiply, sum, round and saturate pipeline. Depends on cpdr_pkg.
`default_nettype none

module cpdr_back #(
  parameter int MAX_LINE    = cpdr_pkg::DEF_MAX_LINE,
  parameter int SAMPLE_BITS = cpdr_pkg::DEF_SAMPLE_BITS,
  parameter int FRAC_BITS   = cpdr_pkg::DEF_FRAC_BITS,
  parameter int OUT_DEPTH   = cpdr_pkg::OUT_Q_DEPTH
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   job_valid,
  input  logic [cpdr_pkg::JOB_SLOTS*SAMPLE_BITS+$clog2(MAX_LINE):0] job_data,
  output logic                                   job_pop,
  input  cpdr_pkg::coef_t                        coef,
  input  logic [$clog2(MAX_LINE)-1:0]            len_last,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]         out_count,
  output logic                                   res_push,
  output logic [SAMPLE_BITS+$clog2(MAX_LINE)+1:0] res_data
);

  import cpdr_pkg::*;

  localparam int CNT_W  = $clog2(MAX_LINE);
  localparam int JOB_W  = JOB_SLOTS * SAMPLE_BITS + CNT_W + 1;
  localparam int OCW    = $clog2(OUT_DEPTH + 1);
  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int PROD_W = DIFF_W + COEF_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int SH_W   = ACC_W - FRAC_BITS;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [2:0] {
    STEP_MID,
    STEP_WRAP_M3,
    STEP_WRAP_M2,
    STEP_WRAP_M1,
    STEP_WRAP_0,
    STEP_WRAP_1,
    STEP_WRAP_2
  } step_t;

  function automatic logic signed [DIFF_W-1:0] diff(input logic [SAMPLE_BITS-1:0] a,
                                                    input logic [SAMPLE_BITS-1:0] b);
    return $signed({a[SAMPLE_BITS-1], a}) - $signed({b[SAMPLE_BITS-1], b});
  endfunction

  step_t                   step;
  logic [SAMPLE_BITS-1:0]  win  [WIN_TAPS];
  logic [SAMPLE_BITS-1:0]  fold [HEAD_DEPTH];
  logic [CNT_W-1:0]        job_pos;
  logic                    job_last;
  logic signed [DIFF_W-1:0] sel1, sel2, sel3;
  logic [CNT_W-1:0]        sel_pos;
  logic                    final_step;
  logic [OCW:0]            pending;
  logic                    issue;

  // stage 0: differences
  logic                     v0;
  logic signed [DIFF_W-1:0] d1, d2, d3;
  logic [CNT_W-1:0]         pos0;
  logic                     done0;
  // stage 1: products
  logic                     v1;
  logic signed [PROD_W-1:0] p1, p2, p3;
  logic [CNT_W-1:0]         pos1;
  logic                     done1;
  // stage 2: rounded sum
  logic                     v2;
  logic signed [ACC_W-1:0]  acc;
  logic [CNT_W-1:0]         pos2;
  logic                     done2;

  logic [SH_W-1:0]          shifted;
  logic [SH_W-SAMPLE_BITS:0] upper;
  logic                     ovf;
  logic [SAMPLE_BITS-1:0]   val;

  always_comb begin
    for (int k = 0; k < WIN_TAPS; k++) begin
      win[k] = job_data[k*SAMPLE_BITS +: SAMPLE_BITS];
    end
    for (int j = 0; j < HEAD_DEPTH; j++) begin
      fold[j] = job_data[(SLOT_FOLD+j)*SAMPLE_BITS +: SAMPLE_BITS];
    end
    job_pos  = job_data[JOB_SLOTS*SAMPLE_BITS +: CNT_W];
    job_last = job_data[JOB_W-1];
  end

  // win[1..6] is the window after the last sample of the line went in
  always_comb begin
    case (step)
      STEP_MID: begin
        sel1 = diff(win[4], win[2]);
        sel2 = diff(win[5], win[1]);
        sel3 = diff(win[6], win[0]);
        sel_pos = job_pos;
      end
      STEP_WRAP_M3: begin
        sel1 = diff(win[5], win[3]);
        sel2 = diff(win[6], win[2]);
        sel3 = diff(fold[0], win[1]);
        sel_pos = len_last - CNT_W'(2);
      end
      STEP_WRAP_M2: begin
        sel1 = diff(win[6], win[4]);
        sel2 = diff(fold[0], win[3]);
        sel3 = diff(fold[1], win[2]);
        sel_pos = len_last - CNT_W'(1);
      end
      STEP_WRAP_M1: begin
        sel1 = diff(fold[0], win[5]);
        sel2 = diff(fold[1], win[4]);
        sel3 = diff(fold[2], win[3]);
        sel_pos = len_last;
      end
      STEP_WRAP_0: begin
        sel1 = diff(fold[1], win[6]);
        sel2 = diff(fold[2], win[5]);
        sel3 = diff(fold[3], win[4]);
        sel_pos = CNT_W'(0);
      end
      STEP_WRAP_1: begin
        sel1 = diff(fold[2], fold[0]);
        sel2 = diff(fold[3], win[6]);
        sel3 = diff(fold[4], win[5]);
        sel_pos = CNT_W'(1);
      end
      STEP_WRAP_2: begin
        sel1 = diff(fold[3], fold[1]);
        sel2 = diff(fold[4], fold[0]);
        sel3 = diff(fold[5], win[6]);
        sel_pos = CNT_W'(2);
      end
      default: begin
        sel1 = '0;
        sel2 = '0;
        sel3 = '0;
        sel_pos = '0;
      end
    endcase
  end

  // issue only with a guaranteed slot in the result queue for everything in flight
  assign pending    = (OCW+1)'(out_count) + (OCW+1)'(v0) + (OCW+1)'(v1) + (OCW+1)'(v2);
  assign issue      = job_valid && (pending < (OCW+1)'(OUT_DEPTH));
  assign final_step = !job_last || (step == STEP_WRAP_2);
  assign job_pop    = issue && final_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_MID;
      v0   <= 1'b0;
      v1   <= 1'b0;
      v2   <= 1'b0;
    end else begin
      if (issue) step <= final_step ? STEP_MID : step_t'(step + 3'd1);
      v0 <= issue;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    d1    <= sel1;
    d2    <= sel2;
    d3    <= sel3;
    pos0  <= sel_pos;
    done0 <= job_last && (step == STEP_WRAP_2);
    p1    <= d1 * $signed(coef.one);
    p2    <= d2 * $signed(coef.two);
    p3    <= d3 * $signed(coef.three);
    pos1  <= pos0;
    done1 <= done0;
    acc   <= p1 + p2 + p3 + HALF;
    pos2  <= pos1;
    done2 <= done1;
  end

  // arithmetic shift drops the fraction; saturate when the top bits disagree
  always_comb begin
    shifted = acc[ACC_W-1:FRAC_BITS];
    upper   = shifted[SH_W-1:SAMPLE_BITS-1];
    ovf     = !((&upper) || !(|upper));
    if (ovf) val = acc[ACC_W-1] ? SAT_MIN : SAT_MAX;
    else val = shifted[SAMPLE_BITS-1:0];
  end

  assign res_push = v2;
  assign res_data = {val, pos2, ovf, done2};

endmodule

`default_nettype wire

### hdl/periodic_compact_derivative_rhs.sv
// Periodic 7-point compact-difference RHS. A sample's result passes the job queue, difference,
// product and rounded-sum stages and result queue; one sample per cycle goes in while the job
// queue has room. Results issue one per cycle while the result queue has room, six wrap results
// at a line end; a line of L samples yields L results, the result queue absorbing the burst.
// Reset (rst, synchronous): coefficients 0, line length 64, queues and pipeline emptied,
// position counter 0; head and window samples are not cleared.
`default_nettype none

module periodic_compact_derivative_rhs #(
  parameter int MAX_LINE    = cpdr_pkg::DEF_MAX_LINE,
  parameter int SAMPLE_BITS = cpdr_pkg::DEF_SAMPLE_BITS,
  parameter int FRAC_BITS   = cpdr_pkg::DEF_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic [SAMPLE_BITS-1:0]             sample,
  output logic                               empty,
  input  logic                               pop,
  output logic [SAMPLE_BITS-1:0]             derivative,
  output logic [$clog2(MAX_LINE)-1:0]        position,
  output logic                               overflow,
  output logic                               line_done,
  input  logic                               wr_en,
  input  logic [cpdr_pkg::REG_IDX_W-1:0]     wr_index,
  input  logic [cpdr_pkg::CFG_DATA_W-1:0]    wr_data
);

  import cpdr_pkg::*;

  localparam int CNT_W  = $clog2(MAX_LINE);
  localparam int JOB_W  = JOB_SLOTS * SAMPLE_BITS + CNT_W + 1;
  localparam int RES_W  = SAMPLE_BITS + CNT_W + 2;
  localparam int OCW    = $clog2(OUT_Q_DEPTH + 1);
  localparam int LEN_CW = (LINE_LEN_W > $clog2(MAX_LINE + 1)) ? LINE_LEN_W
                                                              : $clog2(MAX_LINE + 1);
  localparam int RST_LEN = (LINE_LEN_RESET > MAX_LINE) ? MAX_LINE : LINE_LEN_RESET;
  localparam logic [CNT_W-1:0] RST_LEN_LAST = CNT_W'(RST_LEN - 1);
  localparam logic [WRAP_BASE_W-1:0] RST_WRAP_BASE =
    (RST_LEN < 2 * HEAD_DEPTH) ? WRAP_BASE_W'(RST_LEN - HEAD_DEPTH) : WRAP_BASE_W'(HEAD_DEPTH);

  coef_t                   coef;
  logic [CNT_W-1:0]        len_last;
  logic [WRAP_BASE_W-1:0]  wrap_base;
  logic [LEN_CW-1:0]       len_raw;
  logic [LEN_CW-1:0]       len_clamp;
  logic [CNT_W-1:0]        len_last_next;
  logic [WRAP_BASE_W-1:0]  wrap_base_next;

  logic                    job_push;
  logic [JOB_W-1:0]        job_in;
  logic [JOB_W-1:0]        job_out;
  logic                    job_full;
  logic                    job_empty;
  logic                    job_pop;
  logic                    res_push;
  logic [RES_W-1:0]        res_in;
  logic [RES_W-1:0]        res_out;
  logic [OCW-1:0]          res_count;

  // line length is clamped once at write time; wrap_base is where the
  // window starts overlapping the head (HEAD_DEPTH means no overlap)
  always_comb begin
    len_raw = LEN_CW'(wr_data[LINE_LEN_W-1:0]);
    if (len_raw < LEN_CW'(MIN_LINE)) len_clamp = LEN_CW'(MIN_LINE);
    else if (len_raw > LEN_CW'(MAX_LINE)) len_clamp = LEN_CW'(MAX_LINE);
    else len_clamp = len_raw;
    len_last_next = CNT_W'(len_clamp - LEN_CW'(1));
    if (len_clamp < LEN_CW'(2 * HEAD_DEPTH)) begin
      wrap_base_next = WRAP_BASE_W'(len_clamp - LEN_CW'(HEAD_DEPTH));
    end else begin
      wrap_base_next = WRAP_BASE_W'(HEAD_DEPTH);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef      <= '0;
      len_last  <= RST_LEN_LAST;
      wrap_base <= RST_WRAP_BASE;
    end else if (wr_en) begin
      case (wr_index)
        REG_COEF_ONE:   coef.one   <= wr_data[COEF_W-1:0];
        REG_COEF_TWO:   coef.two   <= wr_data[COEF_W-1:0];
        REG_COEF_THREE: coef.three <= wr_data[COEF_W-1:0];
        REG_LINE_LENGTH: begin
          len_last  <= len_last_next;
          wrap_base <= wrap_base_next;
        end
        default: ;
      endcase
    end
  end

  cpdr_front #(
    .MAX_LINE    (MAX_LINE),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .sample    (sample),
    .full      (full),
    .len_last  (len_last),
    .wrap_base (wrap_base),
    .q_full    (job_full),
    .job_push  (job_push),
    .job_data  (job_in)
  );

  cpdr_queue #(
    .WIDTH (JOB_W),
    .DEPTH (ITEM_Q_DEPTH)
  ) u_job_q (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (job_in),
    .pop       (job_pop),
    .pop_data  (job_out),
    .full      (job_full),
    .empty     (job_empty),
    .count     ()
  );

  cpdr_back #(
    .MAX_LINE    (MAX_LINE),
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS),
    .OUT_DEPTH   (OUT_Q_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (!job_empty),
    .job_data  (job_out),
    .job_pop   (job_pop),
    .coef      (coef),
    .len_last  (len_last),
    .out_count (res_count),
    .res_push  (res_push),
    .res_data  (res_in)
  );

  cpdr_queue #(
    .WIDTH (RES_W),
    .DEPTH (OUT_Q_DEPTH)
  ) u_res_q (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_in),
    .pop       (pop),
    .pop_data  (res_out),
    .full      (),
    .empty     (empty),
    .count     (res_count)
  );

  assign derivative = res_out[RES_W-1 -: SAMPLE_BITS];
  assign position   = res_out[2 +: CNT_W];
  assign overflow   = res_out[1];
  assign line_done  = res_out[0];

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps
// Testbench for periodic_compact_derivative_rhs: directed and random sample lines,
// results predicted in-bench and checked per transfer. Needs hdl/cpdr_pkg.sv and the RTL.
module tb;
  import cpdr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE = 20;
  localparam int FRAC = DEF_FRAC_BITS;
  localparam int ITEM_TARGET = 250;
  localparam logic signed [127:0] ROUND_HALF = 1 << (FRAC - 1);
  localparam logic signed [127:0] SAT_HI = 32'h7FFFFFFF;
  localparam logic signed [127:0] SAT_LO = -SAT_HI - 1;

  typedef struct {
    logic signed [31:0] value;
    logic [11:0] pos;
    logic sat;
    logic last;
  } deriv_t;

  logic clk, rst;
  logic push, full, empty, pop;
  logic [31:0] sample;
  logic [31:0] derivative;
  logic [11:0] position;
  logic overflow, line_done;
  logic wr_en;
  logic [REG_IDX_W-1:0] wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  // predictor state
  logic signed [31:0] coef_one_q, coef_two_q, coef_three_q;
  logic [LINE_LEN_W-1:0] line_len_q;
  logic signed [31:0] line_head [HEAD_DEPTH];
  logic signed [31:0] line_tail [HEAD_DEPTH];
  int unsigned line_pos;

  logic [31:0] pending_samples [$];
  deriv_t expected_derivs [$];

  int send_idle_pct, recv_idle_pct;
  bit recv_hold_req;
  int recv_hold_left;
  int error_count, checked_count, lines_closed, sat_seen, sent_count, queued_total;
  int cycle_count;

  periodic_compact_derivative_rhs u_dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .sample(sample),
    .empty(empty), .pop(pop),
    .derivative(derivative), .position(position),
    .overflow(overflow), .line_done(line_done),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_length();
    if (line_len_q < MIN_LINE) return MIN_LINE;
    if (line_len_q > DEF_MAX_LINE) return DEF_MAX_LINE;
    return line_len_q;
  endfunction

  // index j of the current line: last six come from the tail, first six from the head
  function automatic logic signed [31:0] tap_at(int unsigned j, int unsigned len);
    if (j >= len - HEAD_DEPTH) return line_tail[j - (len - HEAD_DEPTH)];
    return (j < HEAD_DEPTH) ? line_head[j] : '0;
  endfunction

  function automatic void emit_derivative(logic signed [32:0] d1, logic signed [32:0] d2,
                                          logic signed [32:0] d3, int unsigned p, bit last);
    logic signed [127:0] acc;
    deriv_t r;
    acc = d1 * coef_one_q + d2 * coef_two_q + d3 * coef_three_q + ROUND_HALF;
    acc = acc >>> FRAC;
    r.sat = 1'b0;
    if (acc > SAT_HI) begin
      r.value = 32'h7FFFFFFF;
      r.sat = 1'b1;
    end else if (acc < SAT_LO) begin
      r.value = 32'h80000000;
      r.sat = 1'b1;
    end else begin
      r.value = acc[31:0];
    end
    r.pos = p[11:0];
    r.last = last;
    expected_derivs.push_back(r);
  endfunction

  function automatic void take_sample(logic signed [31:0] s);
    int unsigned n, len, p, up, dn;
    logic signed [32:0] d [3];
    n = line_pos;
    len = eff_length();
    if (n < HEAD_DEPTH) begin
      line_head[n] = s;
    end else begin
      d[0] = line_tail[4] - line_tail[2];
      d[1] = line_tail[5] - line_tail[1];
      d[2] = s - line_tail[0];
      emit_derivative(d[0], d[1], d[2], n - STENCIL_REACH, 1'b0);
    end
    for (int k = 0; k < HEAD_DEPTH - 1; k++) line_tail[k] = line_tail[k + 1];
    line_tail[HEAD_DEPTH - 1] = s;
    // last index (or past it after a length change): six wrapped positions follow
    if (n >= len - 1) begin
      for (int t = 0; t < 6; t++) begin
        p = (t < 3) ? len - 3 + t : t - 3;
        for (int k = 1; k <= 3; k++) begin
          up = (p + k) % len;
          dn = (p + len - k) % len;
          d[k - 1] = tap_at(up, len) - tap_at(dn, len);
        end
        emit_derivative(d[0], d[1], d[2], p, t == 5);
      end
      line_pos = 0;
    end else begin
      line_pos = n + 1;
    end
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s (result %0d): got %0d, expected %0d", what, checked_count, got, want);
    error_count++;
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        take_sample(sample);
        void'(pending_samples.pop_front());
        sent_count++;
      end
      if (push && full) begin
        // offer stays up until the transfer
      end else if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        push <= 1'b1;
        sample <= pending_samples[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    deriv_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_derivs.size() == 0) begin
          report_mismatch("result with nothing pending, position", position, -1);
        end else begin
          want = expected_derivs.pop_front();
          if (derivative !== want.value)
            report_mismatch("derivative", $signed(derivative), want.value);
          if (position !== want.pos) report_mismatch("position", position, want.pos);
          if (overflow !== want.sat) report_mismatch("overflow", overflow, want.sat);
          if (line_done !== want.last) report_mismatch("line_done", line_done, want.last);
          if (want.last) lines_closed++;
          if (want.sat) sat_seen++;
        end
        checked_count++;
      end
      if (recv_hold_req) begin
        recv_hold_left = 300;
        recv_hold_req = 1'b0;
      end
      if (recv_hold_left > 0) begin
        recv_hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_derivs.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(reg_index_t idx, logic [31:0] data);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      REG_COEF_ONE:    coef_one_q = data;
      REG_COEF_TWO:    coef_two_q = data;
      REG_COEF_THREE:  coef_three_q = data;
      REG_LINE_LENGTH: line_len_q = data[LINE_LEN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic write_all(logic [31:0] c1, logic [31:0] c2, logic [31:0] c3,
                           logic [31:0] len);
    write_reg(REG_COEF_ONE, c1);
    write_reg(REG_COEF_TWO, c2);
    write_reg(REG_COEF_THREE, c3);
    write_reg(REG_LINE_LENGTH, len);
  endtask

  // wait for every transfer to complete, then let the pipe clear while idle
  task automatic drain_and_settle();
    while (pending_samples.size() != 0 || expected_derivs.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic queue_sample(logic [31:0] s);
    pending_samples.push_back(s);
    queued_total++;
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4: return $urandom_range(1000) - 500;
      5: return 32'h7FFFFFFF;
      6: return 32'h80000000;
      7: return '0;
      8: return '1;
      default: return $urandom_range(2097151) - 1048576;
    endcase
  endfunction

  function automatic logic [31:0] pick_coef(real weight);
    int scaled;
    scaled = $rtoi(weight * 16777216.0 / real'($urandom_range(1, 8)));
    case ($urandom_range(7))
      0, 1: return $urandom;
      2, 3: return scaled;
      4: return -scaled;
      5: return 32'h7FFFFFFF;
      6: return 32'h80000000;
      default: return $urandom_range(3) << (FRAC - 2);  // quarter steps hit rounding ties
    endcase
  endfunction

  function automatic logic [31:0] pick_length();
    logic [31:0] len;
    case ($urandom_range(9))
      0: len = $urandom_range(6);
      1: len = $urandom_range(8191, 4097);
      2: len = DEF_MAX_LINE;
      3: len = $urandom_range(40, 17);
      default: len = $urandom_range(16, 7);
    endcase
    if ($urandom_range(3) == 0) len |= $urandom & 32'hFFFFE000;
    return len;
  endfunction

  initial begin
    real w_one, w_two, w_three;
    int seg_len;
    w_one = 17.0 / 24.0;
    w_two = 101.0 / 600.0;
    w_three = 1.0 / 600.0;
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    sample = '0;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    coef_one_q = '0;
    coef_two_q = '0;
    coef_three_q = '0;
    line_len_q = LINE_LEN_RESET;
    line_pos = 0;
    recv_hold_req = 1'b0;
    recv_hold_left = 0;
    send_idle_pct = 28;
    recv_idle_pct = 63;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // full-scale weights and samples: saturation in both directions
    write_all(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, MIN_LINE);
    queue_sample(32'h7FFFFFFF);
    queue_sample(32'h80000000);
    queue_sample(32'h00000000);
    queue_sample(32'hFFFFFFFF);
    queue_sample(32'h00000001);
    queue_sample(32'h7FFFFFFF);
    queue_sample(32'h80000000);
    drain_and_settle();

    // half-unit weights give exact ties; length below the minimum acts as 7
    write_all(32'h00800000, 32'hFF800000, 32'h00000001, 3);
    queue_sample(0);
    queue_sample(1);
    queue_sample(-1);
    queue_sample(2);
    queue_sample(-2);
    queue_sample(3);
    queue_sample(5);
    drain_and_settle();

    // oversize length clamps; shrinking it mid-line ends the line on the next sample
    write_all($rtoi(w_one * 16777216.0), $rtoi(w_two * 16777216.0),
              $rtoi(w_three * 16777216.0), 8191);
    repeat (9) queue_sample(rand_sample());
    drain_and_settle();
    write_reg(REG_LINE_LENGTH, MIN_LINE);
    queue_sample(rand_sample());
    drain_and_settle();

    // long receiver stall while samples keep coming: input side must back up
    write_reg(REG_LINE_LENGTH, 12);
    recv_hold_req = 1'b1;
    repeat (40) queue_sample(rand_sample());

    while (queued_total < ITEM_TARGET) begin
      drain_and_settle();
      if (queued_total < 120) begin
        send_idle_pct = 28;
        recv_idle_pct = 63;
      end else if (queued_total < 185) begin
        send_idle_pct = 63;
        recv_idle_pct = 28;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if ($urandom_range(1)) write_reg(REG_COEF_ONE, pick_coef(w_one));
      if ($urandom_range(1)) write_reg(REG_COEF_TWO, pick_coef(w_two));
      if ($urandom_range(1)) write_reg(REG_COEF_THREE, pick_coef(w_three));
      if ($urandom_range(2) != 0) write_reg(REG_LINE_LENGTH, pick_length());
      seg_len = $urandom_range(24, 4);
      repeat (seg_len) queue_sample(rand_sample());
    end

    while (pending_samples.size() != 0 || expected_derivs.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (expected_derivs.size() != 0)
      report_mismatch("results never delivered", 0, expected_derivs.size());

    $display("Covered: saturating and tie-rounding lines, clamped lengths, mid-line length");
    $display("changes, a long output stall; %0d samples in, %0d results, %0d lines, %0d sat",
             sent_count, checked_count, lines_closed, sat_seen);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
